FILE: rtl/md5_digest_engine_core_defines.svh
// Assertion macros for the MD5 digest engine checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MD5_DIGEST_ENGINE_CORE_DEFINES_SVH
`define MD5_DIGEST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MD5_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/md5_pkg.sv
// Shared types, constants and round functions of the MD5 digest engine.
// No dependencies.
package md5_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_MARK,
    S_PAD_FILL,
    S_LOAD,
    S_ROUND,
    S_ADD,
    S_DONE
  } md5_state_e;

  localparam int unsigned MSG_WORDS = 16;

  localparam logic [7:0]  PAD_BYTE      = 8'h80;
  localparam logic [5:0]  LAST_POS      = 6'd63;
  localparam logic [5:0]  LAST_ROUND    = 6'd63;
  localparam logic [3:0]  LAST_WORD     = 4'd15;
  localparam logic [3:0]  LEN_WORD_LO   = 4'd14;
  localparam logic [3:0]  LEN_WORD_HI   = 4'd15;
  localparam logic [1:0]  LAST_LANE     = 2'd3;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  localparam logic [1:0] ROUND_F = 2'd0;
  localparam logic [1:0] ROUND_G = 2'd1;
  localparam logic [1:0] ROUND_H = 2'd2;
  localparam logic [1:0] ROUND_I = 2'd3;

  localparam logic [31:0] INIT_WORDS [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Indexed by {round group, round[1:0]}.
  localparam logic [4:0] ROT_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [31:0] md5_f(input logic [1:0] grp, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    logic [31:0] res;
    unique case (grp)
      ROUND_F: res = (b & c) | (~b & d);
      ROUND_G: res = (b & d) | (c & ~d);
      ROUND_H: res = b ^ c ^ d;
      ROUND_I: res = c ^ (b | ~d);
      default: res = '0;
    endcase
    return res;
  endfunction

  // Message word used in a given round; all products are taken modulo 16.
  function automatic logic [3:0] md5_msg_index(input logic [5:0] rnd);
    logic [3:0] i4;
    logic [3:0] idx;
    i4 = rnd[3:0];
    unique case (rnd[5:4])
      ROUND_F: idx = i4;
      ROUND_G: idx = i4 + (i4 << 2) + 4'd1;
      ROUND_H: idx = i4 + (i4 << 1) + 4'd5;
      ROUND_I: idx = (i4 << 3) - i4;
      default: idx = '0;
    endcase
    return idx;
  endfunction

  function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] w;
    w = {x, x} << s;
    return w[63:32];
  endfunction

endpackage

FILE: rtl/md5_stream_if.sv
// Valid/ready channel interfaces of the MD5 digest engine.
// No dependencies.
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output has_byte, output is_last,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input is_last,
                  output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;

  modport source (output valid, output digest_a, output digest_b, output digest_c,
                  output digest_d, input ready);
  modport sink   (input valid, input digest_a, input digest_b, input digest_c,
                  input digest_d, output ready);
endinterface

FILE: rtl/md5_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module md5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/md5_digest_engine_core.sv
// MD5 digest engine top level: byte intake, padding and 64-round compression.
// Depends on md5_pkg, md5_stream_if and md5_ram.
//
//   channel   | dir | payload                                | handshake
//   ----------+-----+----------------------------------------+------------
//   item_i    | in  | data_byte[7:0], has_byte, is_last      | valid/ready
//   digest_o  | out | digest_a, digest_b, digest_c, digest_d | valid/ready
//
// Bytes are taken only while idle; the 64th byte of a block starts a compression
// (load, 64 rounds, chaining add) at one round per cycle, each round reading
// its message word from the 16x32 block RAM. Intake is closed meanwhile.
// A final item adds padding writes, one or two compressions and the posting
// of the digest. Reset needs no clearing pass.
// The digest sits in an output register, so a stalled digest_o does not block
// new bytes; only posting the next digest waits for it to be taken.
module md5_digest_engine_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    item_i,
  md5_out_if.source digest_o
);
  import md5_pkg::*;

  md5_state_e  state_q, state_d;

  logic [5:0]  pos_q, pos_d;
  logic [3:0]  wptr_q, wptr_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [63:0] len_q, len_d;
  logic        last_q, last_d;
  logic        mark_done_q, mark_done_d;
  logic        final_q, final_d;
  logic        out_valid_q, out_valid_d;

  logic [31:0] acc_q, acc_d;
  logic [31:0] a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] out_a_q, out_a_d, out_b_q, out_b_d;
  logic [31:0] out_c_q, out_c_d, out_d_q, out_d_d;

  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;

  logic [31:0] round_f, round_t, round_b;
  logic [31:0] mark_word;
  logic        item_acc;

  md5_ram #(
    .WIDTH (32),
    .DEPTH (MSG_WORDS)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign item_i.ready     = (state_q == S_IDLE);
  assign item_acc         = item_i.valid && (state_q == S_IDLE);
  assign digest_o.valid    = out_valid_q;
  assign digest_o.digest_a = out_a_q;
  assign digest_o.digest_b = out_b_q;
  assign digest_o.digest_c = out_c_q;
  assign digest_o.digest_d = out_d_q;

  // One MD5 round; ram_rdata holds the message word fetched in the cycle before.
  assign round_f = md5_f(rnd_q[5:4], b_q, c_q, d_q);
  assign round_t = a_q + round_f + K_TABLE[rnd_q] + ram_rdata;
  assign round_b = b_q + md5_rotl(round_t, ROT_TABLE[{rnd_q[5:4], rnd_q[1:0]}]);

  // Bytes below the fill lane stay, the lane gets the pad byte, lanes above clear.
  always_comb begin
    mark_word = '0;
    for (int l = 0; l < 4; l++) begin
      if (2'(l) < pos_q[1:0]) begin
        mark_word[8*l +: 8] = acc_q[8*l +: 8];
      end else if (2'(l) == pos_q[1:0]) begin
        mark_word[8*l +: 8] = PAD_BYTE;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (item_i.valid) begin
          if (item_i.has_byte && pos_q == LAST_POS) begin
            state_d = S_LOAD;
          end else if (item_i.is_last) begin
            state_d = S_PAD_MARK;
          end
        end
      end
      S_PAD_MARK: begin
        state_d = (pos_q[5:2] == LAST_WORD) ? S_LOAD : S_PAD_FILL;
      end
      S_PAD_FILL: begin
        if (wptr_q == LAST_WORD) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: state_d = S_ROUND;
      S_ROUND: begin
        if (rnd_q == LAST_ROUND) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (!mark_done_q) begin
          state_d = S_PAD_MARK;
        end else if (!final_q) begin
          state_d = S_PAD_FILL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || digest_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    pos_d       = pos_q;
    wptr_d      = wptr_q;
    rnd_d       = rnd_q;
    len_d       = len_q;
    last_d      = last_q;
    mark_done_d = mark_done_q;
    final_d     = final_q;
    out_valid_d = out_valid_q;
    acc_d       = acc_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    chain_d     = chain_q;
    out_a_d     = out_a_q;
    out_b_d     = out_b_q;
    out_c_d     = out_c_q;
    out_d_d     = out_d_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q[5:2];
    ram_wdata   = acc_q;
    ram_raddr   = '0;

    if (out_valid_q && digest_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (item_acc) begin
          last_d      = item_i.is_last;
          mark_done_d = 1'b0;
          final_d     = 1'b0;
          if (item_i.has_byte) begin
            for (int l = 0; l < 4; l++) begin
              if (2'(l) == pos_q[1:0]) begin
                acc_d[8*l +: 8] = item_i.data_byte;
              end
            end
            len_d = len_q + BITS_PER_BYTE;
            pos_d = pos_q + 6'd1;
            // Word complete: write it to the block RAM.
            if (pos_q[1:0] == LAST_LANE) begin
              ram_we    = 1'b1;
              ram_wdata = acc_d;
            end
          end
        end
      end
      S_PAD_MARK: begin
        ram_we      = 1'b1;
        ram_wdata   = mark_word;
        mark_done_d = 1'b1;
        final_d     = (pos_q[5:2] < LEN_WORD_LO);
        wptr_d      = pos_q[5:2] + 4'd1;
      end
      S_PAD_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = wptr_q;
        if (final_q && wptr_q == LEN_WORD_LO) begin
          ram_wdata = len_q[31:0];
        end else if (final_q && wptr_q == LEN_WORD_HI) begin
          ram_wdata = len_q[63:32];
        end else begin
          ram_wdata = '0;
        end
        wptr_d = wptr_q + 4'd1;
      end
      S_LOAD: begin
        a_d       = chain_q[0];
        b_d       = chain_q[1];
        c_d       = chain_q[2];
        d_d       = chain_q[3];
        rnd_d     = '0;
        ram_raddr = md5_msg_index(6'd0);
      end
      S_ROUND: begin
        a_d       = d_q;
        d_d       = c_q;
        c_d       = b_q;
        b_d       = round_b;
        rnd_d     = rnd_q + 6'd1;
        // Prefetch the word for the next round.
        ram_raddr = md5_msg_index(rnd_q + 6'd1);
      end
      S_ADD: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        // Padding spilled past the length field: start the extra block.
        if (last_q && mark_done_q && !final_q) begin
          final_d = 1'b1;
          wptr_d  = '0;
        end
      end
      S_DONE: begin
        if (!out_valid_q || digest_o.ready) begin
          out_valid_d = 1'b1;
          out_a_d     = chain_q[0];
          out_b_d     = chain_q[1];
          out_c_d     = chain_q[2];
          out_d_d     = chain_q[3];
          chain_d     = INIT_WORDS;
          len_d       = '0;
          pos_d       = '0;
          last_d      = 1'b0;
          mark_done_d = 1'b0;
          final_d     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      wptr_q      <= '0;
      rnd_q       <= '0;
      len_q       <= '0;
      last_q      <= 1'b0;
      mark_done_q <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
      chain_q     <= INIT_WORDS;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      wptr_q      <= wptr_d;
      rnd_q       <= rnd_d;
      len_q       <= len_d;
      last_q      <= last_d;
      mark_done_q <= mark_done_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
      chain_q     <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    a_q     <= a_d;
    b_q     <= b_d;
    c_q     <= c_d;
    d_q     <= d_d;
    out_a_q <= out_a_d;
    out_b_q <= out_b_d;
    out_c_q <= out_c_d;
    out_d_q <= out_d_d;
  end

endmodule

FILE: rtl/md5_checker.sv
// Port-level checks of the MD5 digest engine, bound to its top level.
// Depends on md5_digest_engine_core_defines.svh and md5_digest_engine_core.
`include "md5_digest_engine_core_defines.svh"

module md5_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_has_byte_i,
  input logic        in_is_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] digest_a_i,
  input logic [31:0] digest_d_i
);

  // A stalled digest holds.
  `MD5_ASSERT_NEXT(a_digest_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(digest_a_i) && $stable(digest_d_i), "digest dropped or changed while stalled")

  // A final item starts padding and compression, so intake stops for a while.
  `MD5_ASSERT_NEXT(a_last_busy, in_valid_i && in_ready_i && in_is_last_i, !in_ready_i ##1 !in_ready_i ##1 !in_ready_i, "item taken too soon after a final item")

  // An idle item changes nothing, so intake stays open.
  `MD5_ASSERT_NEXT(a_idle_item, in_valid_i && in_ready_i && !in_has_byte_i && !in_is_last_i, in_ready_i, "idle item stalled intake")

  // A new digest is posted only at the end of a busy phase.
  `MD5_ASSERT_IMPLIES(a_digest_after_busy, $rose(out_valid_i), $past(!in_ready_i), "digest posted while intake was open")

endmodule

bind md5_digest_engine_core md5_checker u_md5_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .in_has_byte_i (item_i.has_byte),
  .in_is_last_i  (item_i.is_last),
  .out_valid_i   (digest_o.valid),
  .out_ready_i   (digest_o.ready),
  .digest_a_i    (digest_o.digest_a),
  .digest_d_i    (digest_o.digest_d)
);
